>>> rtl/core/deq_pkg.sv
`default_nettype none
package deq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_PUSH_HEAD = 2'd0;
  localparam logic [1:0] CMD_PUSH_TAIL = 2'd1;
  localparam logic [1:0] CMD_POP_HEAD  = 2'd2;
  localparam logic [1:0] CMD_REVERSE   = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] data_value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [CNT_W-1:0]   entry_count;
  } rsp_word_t;

  // controller to datapath
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       flip;
    logic       load_imm;
    logic       load_read;
    logic [1:0] status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic reversed;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/double_ended_queue_with_reverse_core.sv
// Bounded double-ended queue of 64 signed 32-bit values in a ring memory,
// with a reverse command that flips which end is the head. Each command word
// yields exactly one response word carrying a status (ok, full, empty), the
// removed value (zero unless a remove succeeded) and the entry count after
// the command. For inserts and reverse the response shows the cycle after
// the command is accepted. A successful remove goes through the registered
// read port of the ring memory, then the response register. One command is
// worked on at a time; the next command is taken as soon as the response
// register is empty or its word is being taken in that cycle. Reset empties
// the queue at once; there is no clearing pass.
`default_nettype none
module double_ended_queue_with_reverse_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_stall,
  input  deq_pkg::cmd_word_t  cmd_word,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output deq_pkg::rsp_word_t  rsp_word
);
  import deq_pkg::*;

  // control and status between the sequencer and the ring datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: decode the word, check full and empty, wait out the read
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (cmd_word.command),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // ring memory, end pointers, count, direction flag and response register
  deq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .data_value (cmd_word.data_value),
    .stat       (dp_stat),
    .rsp_word   (rsp_word)
  );

endmodule
`default_nettype wire

>>> rtl/core/deq_datapath.sv
`default_nettype none
module deq_datapath (
  input  wire                    clk,
  input  wire                    rst,
  input  deq_pkg::dp_cmd_t       cmd,
  input  wire signed [31:0]      data_value,
  output deq_pkg::dp_stat_t      stat,
  output deq_pkg::rsp_word_t     rsp_word
);
  import deq_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [31:0]      entry_store [QUEUE_DEPTH];
  logic [IDX_W-1:0] front_index;
  logic [IDX_W-1:0] back_index;
  logic [CNT_W-1:0] held_count;
  logic             reversed_flag;
  logic [31:0]      rd_data;

  logic [IDX_W-1:0] front_dec, front_inc, back_dec, back_inc;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             wr_en, rd_en;
  logic [CNT_W-1:0] held_count_next;

  always_comb begin
    front_dec = (front_index == '0) ? IDX_LAST : front_index - 1'b1;
    front_inc = (front_index == IDX_LAST) ? '0 : front_index + 1'b1;
    back_dec  = (back_index == '0) ? IDX_LAST : back_index - 1'b1;
    back_inc  = (back_index == IDX_LAST) ? '0 : back_index + 1'b1;
    wr_en     = cmd.push_front | cmd.push_back;
    wr_addr   = cmd.push_front ? front_dec : back_index;
    rd_en     = cmd.pop_front | cmd.pop_back;
    rd_addr   = cmd.pop_front ? front_index : back_dec;
    held_count_next = held_count;
    if (wr_en) begin
      held_count_next = held_count + 1'b1;
    end else if (rd_en) begin
      held_count_next = held_count - 1'b1;
    end
  end

  assign stat.full     = (held_count == CNT_FULL);
  assign stat.empty    = (held_count == '0);
  assign stat.reversed = reversed_flag;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_store[wr_addr] <= data_value;
    end
    if (rd_en) begin
      rd_data <= entry_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index   <= '0;
      back_index    <= '0;
      held_count    <= '0;
      reversed_flag <= 1'b0;
    end else begin
      if (cmd.push_front) front_index <= front_dec;
      if (cmd.pop_front)  front_index <= front_inc;
      if (cmd.push_back)  back_index  <= back_inc;
      if (cmd.pop_back)   back_index  <= back_dec;
      if (cmd.flip)       reversed_flag <= ~reversed_flag;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      rsp_word.status        <= cmd.status;
      rsp_word.removed_value <= '0;
      rsp_word.entry_count   <= held_count_next;
    end else if (cmd.load_read) begin
      rsp_word.status        <= STS_OK;
      rsp_word.removed_value <= rd_data;
      rsp_word.entry_count   <= held_count;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/deq_ctrl.sv
`default_nettype none
module deq_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_stall,
  input  wire [1:0]           command,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  input  deq_pkg::dp_stat_t   stat,
  output deq_pkg::dp_cmd_t    cmd
);
  import deq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state, state_next;
  logic take, to_front;

  assign cmd_stall = !((state == ST_IDLE) && (!rsp_valid || !rsp_stall));
  assign take      = cmd_valid && !cmd_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    to_front   = (command == CMD_PUSH_HEAD) == !stat.reversed;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (command)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
              cmd.load_imm = 1'b1;
              if (stat.full) begin
                cmd.status = STS_FULL;
              end else begin
                cmd.status     = STS_OK;
                cmd.push_front = to_front;
                cmd.push_back  = !to_front;
              end
            end
            CMD_POP_HEAD: begin
              if (stat.empty) begin
                cmd.load_imm = 1'b1;
                cmd.status   = STS_EMPTY;
              end else begin
                cmd.pop_front = !stat.reversed;
                cmd.pop_back  = stat.reversed;
                state_next    = ST_READ;
              end
            end
            CMD_REVERSE: begin
              cmd.flip     = 1'b1;
              cmd.load_imm = 1'b1;
              cmd.status   = STS_OK;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_imm || cmd.load_read) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/deq_chk.sv
`default_nettype none
module deq_chk (
  input wire                 clk,
  input wire                 rst,
  input wire                 rsp_valid,
  input wire                 rsp_stall,
  input deq_pkg::rsp_word_t  rsp_word
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("response word changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status != STS_OK |-> rsp_word.removed_value == '0)
    else $error("refused command returned a value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status == STS_FULL |-> rsp_word.entry_count == CNT_FULL)
    else $error("full status without a full count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status == STS_EMPTY |-> rsp_word.entry_count == '0)
    else $error("empty status with entries held");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_word.entry_count <= CNT_FULL &&
                  (rsp_word.status == STS_OK || rsp_word.status == STS_FULL ||
                   rsp_word.status == STS_EMPTY))
    else $error("response count or status out of range");

endmodule

bind double_ended_queue_with_reverse_core deq_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_word  (rsp_word)
);
`default_nettype wire

>>> test/deq_reply_mirror_pkg.sv
package deq_reply_mirror_pkg;
  import deq_pkg::*;

  // Mirror of the ring-buffer deque: applies each accepted command word to its
  // own copy of the ring and queues the response word that the block must send.
  class deque_reply_mirror;
    logic [31:0]      ring_slots [QUEUE_DEPTH];
    logic [IDX_W-1:0] front_ptr;
    logic [IDX_W-1:0] back_ptr;
    logic [CNT_W-1:0] held;
    bit               flipped;
    rsp_word_t        awaited_replies [$];
    int               mismatch_count;

    function new();
      front_ptr      = '0;
      back_ptr       = '0;
      held           = '0;
      flipped        = 1'b0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    function void mirror_command(cmd_word_t w);
      rsp_word_t reply;
      bit        at_front;
      reply = '0;
      case (w.command)
        CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
          if (held == QUEUE_DEPTH) begin
            reply.status = STS_FULL;
          end else begin
            // the logical head is the physical back while flipped
            at_front = (w.command == CMD_PUSH_HEAD) ^ flipped;
            if (at_front) begin
              front_ptr = (front_ptr == 0) ? IDX_W'(QUEUE_DEPTH - 1) : front_ptr - 1'b1;
              ring_slots[front_ptr] = w.data_value;
            end else begin
              ring_slots[back_ptr] = w.data_value;
              back_ptr = (back_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : back_ptr + 1'b1;
            end
            held = held + 1'b1;
          end
        end
        CMD_POP_HEAD: begin
          if (held == 0) begin
            reply.status = STS_EMPTY;
          end else begin
            if (!flipped) begin
              reply.removed_value = ring_slots[front_ptr];
              front_ptr = (front_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : front_ptr + 1'b1;
            end else begin
              back_ptr = (back_ptr == 0) ? IDX_W'(QUEUE_DEPTH - 1) : back_ptr - 1'b1;
              reply.removed_value = ring_slots[back_ptr];
            end
            held = held - 1'b1;
          end
        end
        default: begin
          flipped = !flipped;
        end
      endcase
      reply.entry_count = held;
      awaited_replies.push_back(reply);
    endfunction

    function void check_reply(rsp_word_t got, longint unsigned stamp);
      rsp_word_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t ns: response word with none awaited: status %0d value %0d count %0d",
                 stamp, got.status, got.removed_value, got.entry_count);
        mismatch_count++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t ns: status expected %0d got %0d", stamp, want.status, got.status);
        mismatch_count++;
      end
      if (got.removed_value !== want.removed_value) begin
        $display("%0t ns: removed_value expected %0d got %0d",
                 stamp, want.removed_value, got.removed_value);
        mismatch_count++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t ns: entry_count expected %0d got %0d",
                 stamp, want.entry_count, got.entry_count);
        mismatch_count++;
      end
    endfunction
  endclass

endpackage

>>> test/tb_double_ended_queue_with_reverse_core.sv
module tb_double_ended_queue_with_reverse_core;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;
  import deq_reply_mirror_pkg::*;

  // Random part length; segments run until this many words have gone in.
  localparam int RANDOM_WORDS = 1530;
  // Cycles with no word moving on either channel before the run is abandoned.
  // The longest legal quiet spell is a sender gap or a receiver stall run
  // plus the ring memory read of a remove, so this limit is many times over
  // anything a correct block needs.
  localparam int QUIET_LIMIT  = 1000;

  // segment flavors for the random part
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_e;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  cmd_word_t cmd_word  = '0;
  logic      rsp_stall = 1'b0;
  logic      cmd_stall;
  logic      rsp_valid;
  rsp_word_t rsp_word;

  deque_reply_mirror mirror;
  bit                no_gaps;       // when set, the sender runs back to back
  int                quiet_cycles;
  int                stall_hold;
  int                words_sent;

  double_ended_queue_with_reverse_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  always #4 clk = ~clk;

  // Sender gap: mostly none, some short, a few long; none at all in a
  // back-to-back segment.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Insert data: lean on the sign boundaries and all-ones/all-zeros now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Drive one word: drop valid for the gap, then hold the word until the
  // block takes it, and hand it to the mirror at the edge where it moves.
  task automatic send_word(input logic [1:0] command, input logic [31:0] value);
    cmd_word_t w;
    int        gap;
    w.command    = command;
    w.data_value = value;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    mirror.mirror_command(w);
    words_sent++;
  endtask

  // Hold the sender off until every awaited response has come back.
  task automatic hold_until_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  // Receiver stall: runs of random length, with the odd long stall and
  // stretches with no stall at all.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(19))
        0, 1, 2: begin
          rsp_stall  <= 1'b0;
          stall_hold = $urandom_range(20, 80);
        end
        3: begin
          rsp_stall  <= 1'b1;
          stall_hold = $urandom_range(10, 40);
        end
        4, 5, 6, 7, 8, 9: begin
          rsp_stall  <= 1'b1;
          stall_hold = $urandom_range(0, 2);
        end
        default: begin
          rsp_stall  <= 1'b0;
          stall_hold = $urandom_range(0, 5);
        end
      endcase
    end
  end

  // Check every response word as it is taken.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      mirror.check_reply(rsp_word, $time);
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    seg_kind_e   kind;
    int          seg_len;
    int          r;
    logic [1:0]  command;

    mirror     = new();
    no_gaps    = 1'b0;
    words_sent = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue corners, both insert ends around a reverse, the
    // sign extremes as data, and removing the last entry.
    send_word(CMD_REVERSE,   $urandom);     // flip while empty
    send_word(CMD_POP_HEAD,  $urandom);     // remove from empty
    send_word(CMD_REVERSE,   $urandom);
    send_word(CMD_PUSH_HEAD, 32'h7fff_ffff);
    send_word(CMD_PUSH_TAIL, 32'h8000_0000);
    send_word(CMD_PUSH_HEAD, 32'h0000_0000);
    send_word(CMD_PUSH_TAIL, 32'hffff_ffff);
    send_word(CMD_POP_HEAD,  $urandom);
    send_word(CMD_REVERSE,   $urandom);
    send_word(CMD_POP_HEAD,  $urandom);
    send_word(CMD_PUSH_HEAD, 32'h5555_5555);
    send_word(CMD_PUSH_TAIL, 32'haaaa_aaaa);
    send_word(CMD_REVERSE,   $urandom);
    send_word(CMD_PUSH_HEAD, 32'h0000_0001);
    send_word(CMD_POP_HEAD,  $urandom);
    send_word(CMD_POP_HEAD,  $urandom);
    send_word(CMD_POP_HEAD,  $urandom);
    send_word(CMD_POP_HEAD,  $urandom);
    send_word(CMD_POP_HEAD,  $urandom);     // last entry leaves
    send_word(CMD_POP_HEAD,  $urandom);     // empty again
    send_word(CMD_PUSH_TAIL, 32'hdead_beef);
    send_word(CMD_POP_HEAD,  $urandom);
    hold_until_drained();

    // Random: segments that lean toward filling (to reach full), draining
    // (to reach empty) or a plain mix, with reverses sprinkled throughout.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      r       = $urandom_range(9);
      kind    = (r < 4) ? SEG_FILL : (r < 7) ? SEG_DRAIN : SEG_MIXED;
      seg_len = $urandom_range(20, 100);
      no_gaps = ($urandom_range(3) == 0);
      repeat (seg_len) begin
        r = $urandom_range(99);
        case (kind)
          SEG_FILL:
            command = (r < 45) ? CMD_PUSH_HEAD : (r < 85) ? CMD_PUSH_TAIL :
                      (r < 93) ? CMD_POP_HEAD  : CMD_REVERSE;
          SEG_DRAIN:
            command = (r < 8)  ? CMD_PUSH_HEAD : (r < 16) ? CMD_PUSH_TAIL :
                      (r < 90) ? CMD_POP_HEAD  : CMD_REVERSE;
          default:
            command = (r < 30) ? CMD_PUSH_HEAD : (r < 60) ? CMD_PUSH_TAIL :
                      (r < 90) ? CMD_POP_HEAD  : CMD_REVERSE;
        endcase
        send_word(command, pick_value());
      end
      // now and then let the block run dry between segments
      if ($urandom_range(4) == 0) begin
        hold_until_drained();
      end
    end

    // Drop valid, wait out every response, then a few more cycles for stray words.
    cmd_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
